[hdl/grcu_pkg.sv]
// ----------------------------------------------------------------------------
// grcu_pkg
// Shared widths, register codes, reset values and the command and status
// records that join the column unit's controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package grcu_pkg;

	// Payload and register widths.
	localparam int POS_W      = 22;
	localparam int ANG_W      = 16;
	localparam int SCR_W      = 13;
	localparam int COL_W      = 12;
	localparam int CELL_W     = 6;
	localparam int VAL_W      = 8;
	localparam int HGT_W      = 16;
	localparam int FACE_W     = 2;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 22;

	// Fixed-point layout of direction, plane and camera.
	localparam int DIR_FRAC = 14;
	localparam int CAM_W    = 28;   // camera offset, signed Q.14
	localparam int PRD_W    = 44;   // plane times camera
	localparam int RAY_W    = 30;   // ray component, signed Q.14
	localparam int MAG_W    = 30;   // magnitude of a ray component

	localparam logic [HGT_W-1:0] HEIGHT_MAX = '1;

	// Defaults of the top-level parameters.
	localparam int MAP_SIDE_DEF    = 64;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_COLUMNS_DEF = 4096;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X    = 4'd0,
		REG_POS_Y    = 4'd1,
		REG_DIR_X    = 4'd2,
		REG_DIR_Y    = 4'd3,
		REG_PLANE_X  = 4'd4,
		REG_PLANE_Y  = 4'd5,
		REG_SCREEN_W = 4'd6,
		REG_SCREEN_H = 4'd7
	} cfg_reg_t;

	localparam logic [POS_W-1:0] POS_X_RESET   = 22'd2097152;
	localparam logic [POS_W-1:0] POS_Y_RESET   = 22'd2097152;
	localparam logic [ANG_W-1:0] DIR_X_RESET   = 16'hC000;
	localparam logic [ANG_W-1:0] DIR_Y_RESET   = 16'h0000;
	localparam logic [ANG_W-1:0] PLANE_X_RESET = 16'h0000;
	localparam logic [ANG_W-1:0] PLANE_Y_RESET = 16'd10813;
	localparam logic [SCR_W-1:0] SCREEN_W_RESET = 13'd640;
	localparam logic [SCR_W-1:0] SCREEN_H_RESET = 13'd480;

	// Face codes.
	localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd0;
	localparam logic [FACE_W-1:0] FACE_NORTH = 2'd1;
	localparam logic [FACE_W-1:0] FACE_EAST  = 2'd2;
	localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

	typedef struct packed {
		logic clear_step;   // clear one map entry
		logic accept;       // input item taken this cycle
		logic div_cam;      // start camera division
		logic ray_mul;      // plane times camera
		logic ray_init;     // form ray, step signs and first distances
		logic step_mul;     // cross products for the step decision
		logic step;         // take one grid step and read the map
		logic look;         // evaluate the cell just entered
		logic h_mul;        // screen height times ray magnitude
		logic div_h;        // start wall height division
		logic load_result;  // fill the output register
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic cast_go;
		logic div_done;
		logic start_ok;
		logic look_out;
		logic look_hit;
		logic look_last;
		logic zero_dist;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

[hdl/grcu_if.sv]
// ----------------------------------------------------------------------------
// grcu_if
// Valid/ready channels of the column unit: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface grcu_item_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [grcu_pkg::COL_W-1:0]    column;
	logic [grcu_pkg::CELL_W-1:0]   cell_x;
	logic [grcu_pkg::CELL_W-1:0]   cell_y;
	logic [grcu_pkg::VAL_W-1:0]    cell_value;

	modport source (output valid, mode, column, cell_x, cell_y, cell_value, input ready);
	modport sink   (input valid, mode, column, cell_x, cell_y, cell_value, output ready);
endinterface

interface grcu_result_if;
	logic                          valid;
	logic                          ready;
	logic [grcu_pkg::COL_W-1:0]    out_column;
	logic [grcu_pkg::HGT_W-1:0]    wall_height;
	logic [grcu_pkg::FACE_W-1:0]   face;
	logic                          hit;

	modport source (output valid, out_column, wall_height, face, hit, input ready);
	modport sink   (input valid, out_column, wall_height, face, hit, output ready);
endinterface

interface grcu_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [grcu_pkg::CFG_IDX_W-1:0]    index;
	logic [grcu_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/grcu_div.sv]
// ----------------------------------------------------------------------------
// grcu_div
// Restoring unsigned divider, one quotient bit per cycle. done pulses for one
// cycle when the quotient is ready; it stays on quo until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module grcu_div #(
	parameter int NUM_W = 45,
	parameter int DEN_W = 25
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

[hdl/grcu_datapath.sv]
// ----------------------------------------------------------------------------
// grcu_datapath
// Registers, wall map, ray setup, DDA stepping, shared divider and the output
// register of the column unit. Sequenced by grcu_ctrl.
// ----------------------------------------------------------------------------
`default_nettype none

module grcu_datapath #(
	parameter int MAP_SIDE    = grcu_pkg::MAP_SIDE_DEF,
	parameter int FRAC_BITS   = grcu_pkg::FRAC_BITS_DEF,
	parameter int MAX_COLUMNS = grcu_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire grcu_pkg::dp_cmd_t                 cmd,
	output grcu_pkg::dp_stat_t                     stat,
	input  wire logic                              cfg_we,
	input  wire logic [grcu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [grcu_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              item_mode,
	input  wire logic [grcu_pkg::COL_W-1:0]        item_column,
	input  wire logic [grcu_pkg::CELL_W-1:0]       item_cell_x,
	input  wire logic [grcu_pkg::CELL_W-1:0]       item_cell_y,
	input  wire logic [grcu_pkg::VAL_W-1:0]        item_cell_value,
	input  wire logic                              res_ready,
	output logic                                   res_valid,
	output logic      [grcu_pkg::COL_W-1:0]        res_out_column,
	output logic      [grcu_pkg::HGT_W-1:0]        res_wall_height,
	output logic      [grcu_pkg::FACE_W-1:0]       res_face,
	output logic                                   res_hit
);

	localparam int POS_W   = grcu_pkg::POS_W;
	localparam int ANG_W   = grcu_pkg::ANG_W;
	localparam int SCR_W   = grcu_pkg::SCR_W;
	localparam int COL_W   = grcu_pkg::COL_W;
	localparam int CAM_W   = grcu_pkg::CAM_W;
	localparam int PRD_W   = grcu_pkg::PRD_W;
	localparam int RAY_W   = grcu_pkg::RAY_W;
	localparam int MAG_W   = grcu_pkg::MAG_W;
	localparam int HGT_W   = grcu_pkg::HGT_W;
	localparam int FACE_W  = grcu_pkg::FACE_W;
	localparam int DFRAC   = grcu_pkg::DIR_FRAC;

	localparam int MAP_W   = $clog2(MAP_SIDE);
	localparam int MC_W    = MAP_W + 2;
	localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int N_LIMIT = 2 * MAP_SIDE + 2;
	localparam int N_W     = $clog2(N_LIMIT + 1);
	localparam int T_W     = FRAC_BITS + $clog2(N_LIMIT + 2) + 1;
	localparam int P_W     = T_W + MAG_W;
	localparam int UP      = (FRAC_BITS >= DFRAC) ? FRAC_BITS - DFRAC : 0;
	localparam int DOWN    = (FRAC_BITS < DFRAC) ? DFRAC - FRAC_BITS : 0;
	localparam int HN_W    = SCR_W + MAG_W;
	localparam int NUM_W   = HN_W + UP;
	localparam int DEN_W   = T_W + DOWN;

	localparam logic [POS_W-1:0] FRAC_MASK =
		(FRAC_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [T_W-1:0]          UNIT     = T_W'(64'd1 << FRAC_BITS);
	localparam logic signed [CAM_W-1:0] CAM_ONE  = CAM_W'(2 ** DFRAC);
	localparam logic signed [MC_W-1:0]  MC_PLUS  = MC_W'(1);
	localparam logic signed [MC_W-1:0]  MC_MINUS = -MC_W'(1);
	localparam logic signed [MC_W-1:0]  MC_SIDE  = MC_W'(MAP_SIDE);

	// Configuration registers.
	logic        [POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [ANG_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic        [SCR_W-1:0] screen_w_q, screen_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= grcu_pkg::POS_X_RESET;
			pos_y_q    <= grcu_pkg::POS_Y_RESET;
			dir_x_q    <= grcu_pkg::DIR_X_RESET;
			dir_y_q    <= grcu_pkg::DIR_Y_RESET;
			plane_x_q  <= grcu_pkg::PLANE_X_RESET;
			plane_y_q  <= grcu_pkg::PLANE_Y_RESET;
			screen_w_q <= grcu_pkg::SCREEN_W_RESET;
			screen_h_q <= grcu_pkg::SCREEN_H_RESET;
		end else if (cfg_we) begin
			case (grcu_pkg::cfg_reg_t'(cfg_index))
				grcu_pkg::REG_POS_X:    pos_x_q    <= cfg_data[POS_W-1:0];
				grcu_pkg::REG_POS_Y:    pos_y_q    <= cfg_data[POS_W-1:0];
				grcu_pkg::REG_DIR_X:    dir_x_q    <= cfg_data[ANG_W-1:0];
				grcu_pkg::REG_DIR_Y:    dir_y_q    <= cfg_data[ANG_W-1:0];
				grcu_pkg::REG_PLANE_X:  plane_x_q  <= cfg_data[ANG_W-1:0];
				grcu_pkg::REG_PLANE_Y:  plane_y_q  <= cfg_data[ANG_W-1:0];
				grcu_pkg::REG_SCREEN_W: screen_w_q <= cfg_data[SCR_W-1:0];
				grcu_pkg::REG_SCREEN_H: screen_h_q <= cfg_data[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	// Wall map and its clearing pass.
	logic              mem [DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              rd_q;
	logic              item_in_map;
	logic              map_we;
	logic [ADDR_W-1:0] map_waddr;
	logic              map_wdata;
	logic [ADDR_W-1:0] item_addr;
	logic [ADDR_W-1:0] step_addr;

	assign item_in_map = (int'(item_cell_x) < MAP_SIDE) && (int'(item_cell_y) < MAP_SIDE);
	assign item_addr   = ADDR_W'(int'(item_cell_y) * MAP_SIDE + int'(item_cell_x));
	assign map_we      = cmd.clear_step || (cmd.accept && !item_mode && item_in_map);
	assign map_waddr   = cmd.clear_step ? clr_q : item_addr;
	assign map_wdata   = cmd.clear_step ? 1'b0 : (item_cell_value != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			mem[map_waddr] <= map_wdata;
		end
		if (cmd.step) begin
			rd_q <= mem[step_addr];
		end
	end

	// Column latch and the shared divider for camera and wall height division.
	logic [COL_W-1:0]  col_q;
	logic [SCR_W-1:0]  w_eff;
	logic              div_start;
	logic              div_done;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [NUM_W-1:0]  div_quo;
	logic [HN_W-1:0]   hnum_q;
	logic [T_W-1:0]    last_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q <= item_column;
		end
	end

	assign w_eff     = (screen_w_q == '0) ? SCR_W'(1) : screen_w_q;
	assign div_start = cmd.div_cam || cmd.div_h;
	assign div_num   = cmd.div_cam ? (NUM_W'(col_q) << (DFRAC + 1)) : (NUM_W'(hnum_q) << UP);
	assign div_den   = cmd.div_cam ? DEN_W'(w_eff) : (DEN_W'(last_q) << DOWN);

	grcu_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Ray setup.
	logic signed [CAM_W-1:0] cam;
	logic signed [PRD_W-1:0] prx_q, pry_q;
	logic signed [RAY_W-1:0] rdx, rdy;
	logic        [MAG_W-1:0] adx_q, ady_q;
	logic                    sxn_q, syn_q;
	logic        [POS_W-1:0] px_int, py_int, fx, fy;
	logic        [T_W-1:0]   tx_q, ty_q;
	logic signed [MC_W-1:0]  mx_q, my_q;
	logic                    start_ok_q;

	assign cam    = $signed(div_quo[CAM_W-1:0]) - CAM_ONE;
	assign rdx    = RAY_W'(prx_q >>> DFRAC) + RAY_W'(dir_x_q);
	assign rdy    = RAY_W'(pry_q >>> DFRAC) + RAY_W'(dir_y_q);
	assign px_int = pos_x_q >> FRAC_BITS;
	assign py_int = pos_y_q >> FRAC_BITS;
	assign fx     = pos_x_q & FRAC_MASK;
	assign fy     = pos_y_q & FRAC_MASK;

	always_ff @(posedge clk) begin
		if (cmd.ray_mul) begin
			prx_q <= PRD_W'(plane_x_q) * PRD_W'(cam);
			pry_q <= PRD_W'(plane_y_q) * PRD_W'(cam);
		end
	end

	// DDA stepping.
	logic [P_W-1:0]          prod_x_q, prod_y_q;
	logic                    step_x;
	logic signed [MC_W-1:0]  nx, ny, cx, cy;
	logic                    side_q;
	logic                    out_q;
	logic                    hit_q;
	logic [N_W-1:0]          n_q;

	assign step_x = (ady_q == '0) || ((adx_q != '0) && (prod_x_q < prod_y_q));
	assign nx     = mx_q + (sxn_q ? MC_MINUS : MC_PLUS);
	assign ny     = my_q + (syn_q ? MC_MINUS : MC_PLUS);
	assign cx     = step_x ? nx : mx_q;
	assign cy     = step_x ? my_q : ny;
	assign step_addr = ADDR_W'(int'(cy[MAP_W-1:0]) * MAP_SIDE + int'(cx[MAP_W-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.ray_init) begin
			adx_q      <= MAG_W'((rdx < 0) ? -rdx : rdx);
			ady_q      <= MAG_W'((rdy < 0) ? -rdy : rdy);
			sxn_q      <= rdx < 0;
			syn_q      <= rdy < 0;
			tx_q       <= (rdx < 0) ? T_W'(fx) : UNIT - T_W'(fx);
			ty_q       <= (rdy < 0) ? T_W'(fy) : UNIT - T_W'(fy);
			mx_q       <= MC_W'(px_int);
			my_q       <= MC_W'(py_int);
			start_ok_q <= (px_int < POS_W'(MAP_SIDE)) && (py_int < POS_W'(MAP_SIDE))
			              && ((rdx != '0) || (rdy != '0));
			n_q        <= '0;
		end
		if (cmd.step_mul) begin
			prod_x_q <= P_W'(tx_q) * P_W'(ady_q);
			prod_y_q <= P_W'(ty_q) * P_W'(adx_q);
		end
		if (cmd.step) begin
			n_q   <= n_q + 1'b1;
			out_q <= cx[MC_W-1] || cy[MC_W-1] || (cx >= MC_SIDE) || (cy >= MC_SIDE);
			if (step_x) begin
				last_q <= tx_q;
				tx_q   <= tx_q + UNIT;
				mx_q   <= nx;
				side_q <= 1'b0;
			end else begin
				last_q <= ty_q;
				ty_q   <= ty_q + UNIT;
				my_q   <= ny;
				side_q <= 1'b1;
			end
		end
		if (cmd.h_mul) begin
			hnum_q <= HN_W'(screen_h_q) * HN_W'(side_q ? ady_q : adx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.ray_init) begin
			hit_q <= 1'b0;
		end else if (cmd.look) begin
			hit_q <= !out_q && rd_q;
		end
	end

	// Output register.
	logic [HGT_W-1:0]  height;
	logic [FACE_W-1:0] face_w;
	logic              res_valid_q;

	always_comb begin
		if (last_q == '0) begin
			height = grcu_pkg::HEIGHT_MAX;
		end else if (div_quo > NUM_W'(grcu_pkg::HEIGHT_MAX)) begin
			height = grcu_pkg::HEIGHT_MAX;
		end else begin
			height = div_quo[HGT_W-1:0];
		end
		if (side_q) begin
			face_w = syn_q ? grcu_pkg::FACE_NORTH : grcu_pkg::FACE_SOUTH;
		end else begin
			face_w = sxn_q ? grcu_pkg::FACE_WEST : grcu_pkg::FACE_EAST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_out_column  <= col_q;
			res_hit         <= hit_q;
			res_wall_height <= hit_q ? height : '0;
			res_face        <= hit_q ? face_w : grcu_pkg::FACE_SOUTH;
		end
	end

	assign res_valid = res_valid_q;

	assign stat.clear_done = (clr_q == ADDR_W'(DEPTH - 1));
	assign stat.cast_go    = item_mode && (int'(item_column) < MAX_COLUMNS);
	assign stat.div_done   = div_done;
	assign stat.start_ok   = start_ok_q;
	assign stat.look_out   = out_q;
	assign stat.look_hit   = rd_q;
	assign stat.look_last  = (n_q == N_W'(N_LIMIT));
	assign stat.zero_dist  = (last_q == '0);
	assign stat.out_busy   = res_valid_q;

endmodule

`default_nettype wire

[hdl/grcu_ctrl.sv]
// ----------------------------------------------------------------------------
// grcu_ctrl
// Sequencer of the column unit: map clearing after reset, camera division,
// ray setup, the DDA step loop, wall height division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module grcu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output grcu_pkg::dp_cmd_t        cmd,
	input  wire grcu_pkg::dp_stat_t  stat
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CAM_START,
		ST_CAM_WAIT,
		ST_RAY_MUL,
		ST_RAY_INIT,
		ST_CHECK,
		ST_MUL,
		ST_STEP,
		ST_LOOK,
		ST_H_MUL,
		ST_H_START,
		ST_H_WAIT,
		ST_RESULT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd             = '0;
		in_ready        = (state_q == ST_IDLE);
		cmd.accept      = in_ready && in_valid;
		cmd.clear_step  = (state_q == ST_CLEAR);
		cmd.div_cam     = (state_q == ST_CAM_START);
		cmd.ray_mul     = (state_q == ST_RAY_MUL);
		cmd.ray_init    = (state_q == ST_RAY_INIT);
		cmd.step_mul    = (state_q == ST_MUL);
		cmd.step        = (state_q == ST_STEP);
		cmd.look        = (state_q == ST_LOOK);
		cmd.h_mul       = (state_q == ST_H_MUL);
		cmd.div_h       = (state_q == ST_H_START);
		cmd.load_result = (state_q == ST_RESULT) && !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (stat.clear_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && stat.cast_go) state_q <= ST_CAM_START;
				end
				ST_CAM_START: state_q <= ST_CAM_WAIT;
				ST_CAM_WAIT: begin
					if (stat.div_done) state_q <= ST_RAY_MUL;
				end
				ST_RAY_MUL:  state_q <= ST_RAY_INIT;
				ST_RAY_INIT: state_q <= ST_CHECK;
				ST_CHECK: begin
					state_q <= stat.start_ok ? ST_MUL : ST_RESULT;
				end
				ST_MUL:  state_q <= ST_STEP;
				ST_STEP: state_q <= ST_LOOK;
				ST_LOOK: begin
					if (stat.look_out) begin
						state_q <= ST_RESULT;
					end else if (stat.look_hit) begin
						state_q <= ST_H_MUL;
					end else if (stat.look_last) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_H_MUL: begin
					state_q <= stat.zero_dist ? ST_RESULT : ST_H_START;
				end
				ST_H_START: state_q <= ST_H_WAIT;
				ST_H_WAIT: begin
					if (stat.div_done) state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!stat.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/grid_raycast_column_unit.sv]
// ----------------------------------------------------------------------------
// grid_raycast_column_unit
// DDA grid raycaster for one screen column per cast item, with a wall map
// written through map-write items.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake      carries
//   -------  ---------  -------------  ------------------------------------------
//   item     in         valid / ready  mode, column, cell_x, cell_y, cell_value
//   result   out        valid / ready  out_column, wall_height, face, hit
//   cfg      in         valid / ready  index, data (register write)
//
// A map-write item for a cell inside the map is written as it is taken, and
// produces no result. A cast item runs the camera offset division and, on a
// hit at a nonzero distance, the wall height division, each of NUM_W quotient
// bits (45 at the default format), plus a multiply, a step and a look state
// for each grid step, at most 2*MAP_SIDE+2 steps. After reset the map is
// cleared one entry per cycle, all MAP_SIDE squared entries (4096 by
// default), before the first item is taken; configuration writes are taken
// throughout. A stalled result holds in the output register while map
// writes continue; the next cast waits only at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_raycast_column_unit #(
	parameter int MAP_SIDE    = grcu_pkg::MAP_SIDE_DEF,
	parameter int FRAC_BITS   = grcu_pkg::FRAC_BITS_DEF,
	parameter int MAX_COLUMNS = grcu_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	grcu_item_if.sink     item,
	grcu_result_if.source result,
	grcu_cfg_if.sink      cfg
);

	grcu_pkg::dp_cmd_t  cmd;
	grcu_pkg::dp_stat_t stat;

	// Configuration registers are plain flops, so writes are always taken.
	assign cfg.ready = 1'b1;

	// The controller owns the input handshake and steps the datapath through
	// the cast; the datapath owns the map, the divider and the output flop.
	grcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	grcu_datapath #(
		.MAP_SIDE    (MAP_SIDE),
		.FRAC_BITS   (FRAC_BITS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.item_mode       (item.mode),
		.item_column     (item.column),
		.item_cell_x     (item.cell_x),
		.item_cell_y     (item.cell_y),
		.item_cell_value (item.cell_value),
		.res_ready       (result.ready),
		.res_valid       (result.valid),
		.res_out_column  (result.out_column),
		.res_wall_height (result.wall_height),
		.res_face        (result.face),
		.res_hit         (result.hit)
	);

	// No item may be taken while the map is still being cleared.
	a_no_item_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !item.ready)
		else $error("item ready during map clearing");

	// A new result is never loaded over one that is still waiting.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> !result.valid)
		else $error("result register overwritten");

	// A miss carries zero height and face.
	a_miss_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |-> (result.wall_height == '0 && result.face == '0))
		else $error("miss result with nonzero fields");

endmodule

`default_nettype wire
